FILE: design/gil_pkg.sv
// Package for the glyph index interval lookup block.
// Types and codes shared by the controller and datapath, and style helper functions used by the datapath.
// No dependencies.
`default_nettype none

package gil_pkg;

    localparam int CP_W    = 21;
    localparam int IDX_W   = 24;
    localparam int MASK_W  = 4;
    localparam int COUNT_W = 9;
    localparam int SLOT_W  = 8;
    localparam int STYLE_W = 2;
    localparam int CFG_W   = 9;
    localparam int CFGI_W  = 1;
    localparam int ONES_W  = 3;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    localparam logic [CFGI_W-1:0] REG_STYLE_MASK     = 1'd0;
    localparam logic [CFGI_W-1:0] REG_INTERVAL_COUNT = 1'd1;

    localparam logic [STYLE_W-1:0] STYLE_REGULAR     = 2'd0;
    localparam logic [STYLE_W-1:0] STYLE_BOLD        = 2'd1;
    localparam logic [STYLE_W-1:0] STYLE_ITALIC      = 2'd2;
    localparam logic [STYLE_W-1:0] STYLE_BOLD_ITALIC = 2'd3;

    localparam logic [MASK_W-1:0] MASK_R    = 4'b0001;
    localparam logic [MASK_W-1:0] MASK_RB   = 4'b0011;
    localparam logic [MASK_W-1:0] MASK_RI   = 4'b0101;
    localparam logic [MASK_W-1:0] MASK_RBI  = 4'b1001;
    localparam logic [MASK_W-1:0] MASK_RBII = 4'b0111;
    localparam logic [MASK_W-1:0] MASK_RBBI = 4'b1011;
    localparam logic [MASK_W-1:0] MASK_RIBI = 4'b1101;
    localparam logic [MASK_W-1:0] MASK_ALL  = 4'b1111;

    localparam logic [MASK_W-1:0] MASK_RESET = MASK_R;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_COMPARE,
        ST_SUM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start_lookup;
        logic start_write;
        logic probe;
        logic compare;
        logic finish;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic search_open;
        logic hit;
        logic out_free;
    } ctl_status_t;

    function automatic logic [ONES_W-1:0] ones4(input logic [MASK_W-1:0] m);
        ones4 = ONES_W'(m[0]) + ONES_W'(m[1]) + ONES_W'(m[2]) + ONES_W'(m[3]);
    endfunction

    // Rank of the substitute style among the present styles
    function automatic logic [STYLE_W-1:0] style_rank(input logic [MASK_W-1:0] m,
                                                     input logic [STYLE_W-1:0] s);
        logic [STYLE_W-1:0] r;
        r = '0;
        if (s != STYLE_REGULAR) begin
            case (m)
                MASK_R:    r = 2'd0;
                MASK_RB:   r = (s == STYLE_BOLD || s == STYLE_BOLD_ITALIC) ? 2'd1 : 2'd0;
                MASK_RI:   r = (s == STYLE_ITALIC || s == STYLE_BOLD_ITALIC) ? 2'd1 : 2'd0;
                MASK_RBI:  r = 2'd1;
                MASK_RBII: r = (s == STYLE_BOLD_ITALIC) ? 2'd1 : s;
                MASK_RBBI: r = (s == STYLE_BOLD) ? 2'd1 : 2'd2;
                MASK_RIBI: r = (s == STYLE_ITALIC) ? 2'd1 : 2'd2;
                MASK_ALL:  r = s;
                default:   r = 2'd0;
            endcase
        end
        style_rank = r;
    endfunction

endpackage

`default_nettype wire

FILE: design/glyph_index_interval_lookup_top.sv
// Top level of the glyph index interval lookup block.
// Joins gil_ctrl and gil_datapath; uses gil_pkg.
//
// channel   signals                                        direction
// input     in_valid/in_stall, cmd slot range_first ...    in
// output    out_valid/out_stall, found glyph_index         out
// config    cfg_we cfg_index cfg_data                      in
//
// A write item goes from IDLE straight to DONE; a lookup passes ISSUE and COMPARE once
// per probe, up to 9 probes at 256 entries, then SUM on a hit and DONE. Each probe is
// one registered read of the interval memory followed by one compare. The result waits
// in an output register, so the next item is taken while it is stalled. Reset clears
// control and config; the interval memory holds nothing until written.
`default_nettype none

module glyph_index_interval_lookup_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [gil_pkg::CFGI_W-1:0]    cfg_index,
    input  wire logic [gil_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          cmd,
    input  wire logic [gil_pkg::SLOT_W-1:0]    slot,
    input  wire logic [gil_pkg::CP_W-1:0]      range_first,
    input  wire logic [gil_pkg::CP_W-1:0]      range_last,
    input  wire logic [gil_pkg::IDX_W-1:0]     glyph_offset,
    input  wire logic [gil_pkg::CP_W-1:0]      codepoint,
    input  wire logic [gil_pkg::STYLE_W-1:0]   style_req,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               found,
    output logic [gil_pkg::IDX_W-1:0]          glyph_index
);
    import gil_pkg::*;

    ctl_cmd_t    ctl;
    ctl_status_t status;

    gil_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .in_stall (in_stall),
        .status   (status),
        .ctl      (ctl)
    );

    gil_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .slot         (slot),
        .range_first  (range_first),
        .range_last   (range_last),
        .glyph_offset (glyph_offset),
        .codepoint    (codepoint),
        .style_req    (style_req),
        .ctl          (ctl),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .glyph_index  (glyph_index)
    );

endmodule

`default_nettype wire

FILE: design/gil_ctrl.sv
// Controller state machine for the glyph index interval lookup block.
// Sequences item intake, search probes, index sum and result hand-off; uses gil_pkg.
`default_nettype none

module gil_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                cmd,
    output logic                     in_stall,
    input  gil_pkg::ctl_status_t     status,
    output gil_pkg::ctl_cmd_t        ctl
);
    import gil_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (cmd == CMD_LOOKUP)
                    begin
                        ctl.start_lookup = 1'b1;
                        state_next       = ST_ISSUE;
                    end
                    else
                    begin
                        ctl.start_write = 1'b1;
                        state_next      = ST_DONE;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (status.search_open)
                begin
                    ctl.probe  = 1'b1;
                    state_next = ST_COMPARE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_COMPARE:
            begin
                ctl.compare = 1'b1;
                state_next  = status.hit ? ST_SUM : ST_ISSUE;
            end
            ST_SUM:
            begin
                ctl.finish = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/gil_datapath.sv
// Datapath for the glyph index interval lookup block: config registers, interval
// memory, search bounds, index arithmetic and output register. Uses gil_pkg.
`default_nettype none

module gil_datapath #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [gil_pkg::CFGI_W-1:0]    cfg_index,
    input  wire logic [gil_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic [gil_pkg::SLOT_W-1:0]    slot,
    input  wire logic [gil_pkg::CP_W-1:0]      range_first,
    input  wire logic [gil_pkg::CP_W-1:0]      range_last,
    input  wire logic [gil_pkg::IDX_W-1:0]     glyph_offset,
    input  wire logic [gil_pkg::CP_W-1:0]      codepoint,
    input  wire logic [gil_pkg::STYLE_W-1:0]   style_req,
    input  gil_pkg::ctl_cmd_t                  ctl,
    output gil_pkg::ctl_status_t               status,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               found,
    output logic [gil_pkg::IDX_W-1:0]          glyph_index
);
    import gil_pkg::*;

    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PW    = $clog2(TABLE_DEPTH + 1);
    localparam int BW    = PW + 1;
    localparam int LIM_W = (PW > COUNT_W) ? PW : COUNT_W;
    localparam int ENT_W = 2 * CP_W + IDX_W;

    logic [MASK_W-1:0]   mask_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [ENT_W-1:0]    mem [TABLE_DEPTH];
    logic [ENT_W-1:0]    rd_reg;

    logic [CP_W-1:0]     cp_reg;
    logic [STYLE_W-1:0]  req_reg;
    logic signed [BW-1:0] lo_reg;
    logic signed [BW-1:0] hi_reg;
    logic signed [BW-1:0] mid_reg;
    logic signed [BW-1:0] mid;
    logic signed [BW-1:0] hi_init;
    logic [LIM_W-1:0]    cnt_ext;
    logic [LIM_W-1:0]    lim;
    logic                slot_ok;
    logic [AW-1:0]       wr_addr;

    logic [CP_W-1:0]     rd_first;
    logic [CP_W-1:0]     rd_last;
    logic [IDX_W-1:0]    rd_offset;
    logic                below;
    logic                above;

    logic [IDX_W-1:0]    prod_reg;
    logic [IDX_W-1:0]    base_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                out_valid_reg;
    logic                found_out_reg;
    logic [IDX_W-1:0]    index_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= MASK_RESET;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_STYLE_MASK)
            begin
                mask_reg <= cfg_data[MASK_W-1:0];
            end
            if (cfg_index == REG_INTERVAL_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
        end
    end

    assign slot_ok = (LIM_W'(slot) < LIM_W'(TABLE_DEPTH));
    assign wr_addr = AW'(slot);
    assign cnt_ext = LIM_W'(count_reg);
    assign lim     = (cnt_ext > LIM_W'(TABLE_DEPTH)) ? LIM_W'(TABLE_DEPTH) : cnt_ext;
    assign hi_init = $signed(BW'(lim)) - BW'(1);
    assign mid     = lo_reg + ((hi_reg - lo_reg) >>> 1);

    always_ff @(posedge clk)
    begin
        if (ctl.start_write && slot_ok)
        begin
            mem[wr_addr] <= {range_first, range_last, glyph_offset};
        end
        if (ctl.probe)
        begin
            rd_reg <= mem[mid[AW-1:0]];
        end
    end

    assign {rd_first, rd_last, rd_offset} = rd_reg;
    assign below = (cp_reg < rd_first);
    assign above = (cp_reg > rd_last);

    always_ff @(posedge clk)
    begin
        if (ctl.start_lookup)
        begin
            cp_reg  <= codepoint;
            req_reg <= style_req;
            lo_reg  <= '0;
            hi_reg  <= hi_init;
        end
        if (ctl.probe)
        begin
            mid_reg <= mid;
        end
        if (ctl.compare)
        begin
            if (below)
            begin
                hi_reg <= mid_reg - BW'(1);
            end
            else if (above)
            begin
                lo_reg <= mid_reg + BW'(1);
            end
            prod_reg <= IDX_W'(cp_reg - rd_first) * IDX_W'(ones4(mask_reg));
            base_reg <= rd_offset + IDX_W'(style_rank(mask_reg, req_reg));
        end
        if (ctl.finish)
        begin
            idx_reg <= base_reg + prod_reg;
        end
        if (ctl.out_load)
        begin
            found_out_reg <= hit_reg;
            index_out_reg <= hit_reg ? idx_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.start_lookup || ctl.start_write)
            begin
                hit_reg <= 1'b0;
            end
            else if (ctl.compare && !below && !above)
            begin
                hit_reg <= 1'b1;
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.search_open = (lo_reg <= hi_reg);
    assign status.hit         = !below && !above;
    assign status.out_free    = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign found       = found_out_reg;
    assign glyph_index = index_out_reg;

endmodule

`default_nettype wire
